// ===== rtl/core/smse_pkg.sv =====
// Shared constants, types and the sigmoid table for the sigmoid MSE accumulator.
package smse_pkg;

  // Field and storage widths.
  localparam int COUNT_BITS    = 24;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TB            = $clog2(TABLE_ENTRIES);
  localparam int K_W           = 16;
  localparam int SCORE_W       = 16;
  localparam int RES_W         = 2;
  localparam int ROM_W         = 17;
  localparam int ERR_W         = ROM_W + 1;
  localparam int SQ_W          = 33;
  localparam int SUM_W         = 57;
  localparam int MEAN_W        = 33;
  localparam int CNT_W         = COUNT_BITS + 1;
  localparam int DIV_STEP_W    = $clog2(SUM_W);

  // Scaled score: K (Q4.12) times score fits in 32 signed bits.
  localparam int P_W = 32;
  localparam int X_W = P_W + 1;

  // Index math: idx = floor((p + 13107200) / (25 * 2^(20 - TB))).
  localparam int U_OFFSET    = 13107200;
  localparam int CLAMP_HI    = 26214400;
  localparam int IDX_SHIFT   = 20 - TB;
  localparam int Y_W         = TB + 5;
  localparam int RECIP_SHIFT = Y_W + 5;
  localparam int RECIP_W     = TB + 6;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + 24) / 25;
  localparam int PROD_W      = Y_W + RECIP_W;

  // Reset value of the steepness register (1.13 in Q4.12).
  localparam logic [K_W-1:0] K_RESET = 16'd4628;

  // Game result codes; code three is taken as a draw.
  localparam logic [RES_W-1:0] RES_LOSS = 2'd0;
  localparam logic [RES_W-1:0] RES_DRAW = 2'd1;
  localparam logic [RES_W-1:0] RES_WIN  = 2'd2;

  // Targets in Q1.16.
  localparam logic [ROM_W-1:0] TARGET_ZERO = 17'd0;
  localparam logic [ROM_W-1:0] TARGET_HALF = 17'd32768;
  localparam logic [ROM_W-1:0] TARGET_ONE  = 17'd65536;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_BUSY = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  // Sigmoid table type and its build-time generator.
  typedef logic [ROM_W-1:0] rom_tbl_t [TABLE_ENTRIES];

  localparam logic [63:0] LOG2_10_Q32 = 64'h0000_0003_5269_E12F;
  localparam logic [63:0] LN2_Q32     = 64'h0000_0000_B172_17F7;

  // Unsigned long division by shift and subtract, used only for build-time table values.
  function automatic logic [63:0] shift_div(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One entry: round(65536 * sigma(c)) at the cell center, evaluated in fixed point.
  function automatic logic [ROM_W-1:0] rom_entry(input int unsigned idx);
    longint      d;
    logic [63:0] ad;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] tt;
    logic [63:0] den;
    logic [63:0] q;
    longint      x;
    longint      term;
    longint      acc;
    int          k;
    d = 2 * longint'(idx) + 1 - longint'(TABLE_ENTRIES);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    e = (ad * 64'd8 * LOG2_10_Q32) / 64'(TABLE_ENTRIES);
    n = e >> 32;
    f = e & 64'h0000_0000_FFFF_FFFF;
    x = longint'((f * LN2_Q32) >> 34);
    term = longint'(1) << 30;
    acc = term;
    // Series for exp(-x), truncating each term; every term stays non-negative.
    for (k = 1; k <= 12; k++) begin
      term = (term * x) >>> 30;
      term = longint'(shift_div(64'(term), 64'(k)));
      if ((k % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    tt = (n < 64'd63) ? (64'(acc) >> n) : 64'd0;
    den = (64'd1 << 30) + tt;
    if (d >= 0) begin
      q = shift_div((64'd1 << 46) + den / 2, den);
    end else begin
      q = shift_div((tt << 16) + den / 2, den);
    end
    return q[ROM_W-1:0];
  endfunction

  function automatic rom_tbl_t build_rom();
    rom_tbl_t    r;
    int unsigned i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_tbl_t SIG_ROM = build_rom();

endpackage

// ===== rtl/core/smse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smse_ram #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; holds its data while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sigmoid_mse_accumulator.sv =====
// Top level: pipelined sigmoid squared-error accumulator with a serial mean divider.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_write             cfg_data (k_scale)
//   in        in         in_valid / in_stall   eval_score, game_result, last_item
//   out       out        out_valid / out_stall mean_sq_error, sum_sq_error,
//                                              item_count, count_overflow
//
// One word enters per cycle while in_stall is low; five register stages (multiply, offset/clamp,
// reciprocal multiply, table read, square) lead to the accumulator.
// A word marked last hands the totals to a one-bit-per-step divider, whose result word
// appears once all quotient bits are formed.
// After reset all 1024 table entries are written, one entry per cycle, with in_stall
// high; configuration writes are taken throughout.
// The pipeline stalls only when a last word reaches the accumulator while the divider
// is still busy or its result has not been taken.
module sigmoid_mse_accumulator
  import smse_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [K_W-1:0]            cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SCORE_W-1:0] eval_score,
  input  logic [RES_W-1:0]          game_result,
  input  logic                      last_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [MEAN_W-1:0]         mean_sq_error,
  output logic [SUM_W-1:0]          sum_sq_error,
  output logic [CNT_W-1:0]          item_count,
  output logic                      count_overflow
);

  localparam logic signed [X_W-1:0]  OFFSET_X = X_W'(U_OFFSET);
  localparam logic signed [X_W-1:0]  CLAMP_X  = X_W'(CLAMP_HI);
  localparam logic [RECIP_W-1:0]     RECIP_C  = RECIP_W'(RECIP);
  localparam logic [TB-1:0]          ADDR_TOP = TB'(TABLE_ENTRIES - 1);

  // Configuration and table fill.
  logic [K_W-1:0] k_scale;
  logic           fill_busy;
  logic [TB-1:0]  fill_addr;

  // Pipeline stages.
  logic                  s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic signed [P_W-1:0] s1_prod;
  logic [RES_W-1:0]      s1_res, s2_res, s3_res, s4_res;
  logic                  s1_last, s2_last, s3_last, s4_last, s5_last;
  logic [Y_W-1:0]        s2_y;
  logic                  s2_lo, s2_hi, s3_lo, s3_hi;
  logic [PROD_W-1:0]     s3_prod;
  logic [ROM_W-1:0]      s4_rom;
  logic [SQ_W-1:0]       s5_sq;

  // Accumulators.
  logic [SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0] acc_count;
  logic             acc_ovf;

  // Divider and result hold.
  div_state_t            div_state;
  logic [DIV_STEP_W-1:0] div_step;
  logic [CNT_W-1:0]      div_rem;
  logic [SUM_W-1:0]      div_dq;
  logic [SUM_W-1:0]      hold_sum;
  logic [CNT_W-1:0]      hold_count;
  logic                  hold_ovf;

  // Combinational signals.
  logic                        div_free, freeze, advance, in_accept, consume, div_load;
  logic signed [K_W+SCORE_W:0] mult_full;
  logic signed [X_W-1:0]       x_sum;
  logic [PROD_W-1:0]           y_mult;
  logic [TB-1:0]               rom_addr;
  logic [ROM_W-1:0]            target;
  logic signed [ERR_W-1:0]     err;
  logic signed [2*ERR_W-1:0]   sq_full;
  logic                        at_bound;
  logic [SUM_W:0]              sum_add;
  logic [SUM_W-1:0]            sum_next;
  logic [CNT_W-1:0]            count_next;
  logic                        ovf_next;
  logic [CNT_W:0]              trial;
  logic [CNT_W:0]              trial_diff;
  logic                        trial_ok;

  // Flow control: only a last word blocked at the divider holds the pipeline.
  assign div_free  = (div_state == DIV_IDLE) || ((div_state == DIV_DONE) && !out_stall);
  assign freeze    = s5_valid && s5_last && !div_free;
  assign advance   = !freeze;
  assign in_stall  = fill_busy || freeze;
  assign in_accept = in_valid && !in_stall;
  assign consume   = advance && s5_valid;
  assign div_load  = consume && s5_last;

  // Steepness register.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_scale <= K_RESET;
    end else if (cfg_write) begin
      k_scale <= cfg_data;
    end
  end

  // Table fill sweep after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_addr <= '0;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == ADDR_TOP) begin
        fill_busy <= 1'b0;
      end
    end
  end

  // Stage arithmetic.
  assign mult_full = $signed({1'b0, k_scale}) * eval_score;
  assign x_sum     = {s1_prod[P_W-1], s1_prod} + OFFSET_X;
  assign y_mult    = PROD_W'(s2_y) * PROD_W'(RECIP_C);
  assign rom_addr  = s3_lo ? '0 : (s3_hi ? ADDR_TOP : s3_prod[RECIP_SHIFT +: TB]);

  // Target for the game result.
  always_comb begin
    case (s4_res)
      RES_LOSS: target = TARGET_ZERO;
      RES_WIN:  target = TARGET_ONE;
      RES_DRAW: target = TARGET_HALF;
      default:  target = TARGET_HALF;
    endcase
  end

  assign err     = $signed({1'b0, target}) - $signed({1'b0, s4_rom});
  assign sq_full = err * err;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod <= mult_full[P_W-1:0];
      s1_res  <= game_result;
      s1_last <= last_item;
      s2_y    <= x_sum[IDX_SHIFT +: Y_W];
      s2_lo   <= x_sum[X_W-1];
      s2_hi   <= (x_sum >= CLAMP_X);
      s2_res  <= s1_res;
      s2_last <= s1_last;
      s3_prod <= y_mult;
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
      s3_res  <= s2_res;
      s3_last <= s2_last;
      s4_res  <= s3_res;
      s4_last <= s3_last;
      s5_sq   <= sq_full[SQ_W-1:0];
      s5_last <= s4_last;
    end
  end

  // Sigmoid table.
  smse_ram #(
    .DATA_W (ROM_W),
    .DEPTH  (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (fill_busy),
    .wr_addr (fill_addr),
    .wr_data (SIG_ROM[fill_addr]),
    .rd_en   (advance),
    .rd_addr (rom_addr),
    .rd_data (s4_rom)
  );

  // Saturating sum and bounded count.
  assign at_bound   = acc_count[COUNT_BITS];
  assign sum_add    = {1'b0, acc_sum} + (SUM_W + 1)'(s5_sq);
  assign sum_next   = at_bound ? acc_sum : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
  assign count_next = at_bound ? acc_count : acc_count + 1'b1;
  assign ovf_next   = acc_ovf | at_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum   <= '0;
      acc_count <= '0;
      acc_ovf   <= 1'b0;
    end else if (consume) begin
      if (s5_last) begin
        acc_sum   <= '0;
        acc_count <= '0;
        acc_ovf   <= 1'b0;
      end else begin
        acc_sum   <= sum_next;
        acc_count <= count_next;
        acc_ovf   <= ovf_next;
      end
    end
  end

  // Divider sequencer: one quotient bit per step, then hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
      div_step  <= '0;
    end else if (div_load) begin
      div_state <= DIV_BUSY;
      div_step  <= DIV_STEP_W'(SUM_W - 1);
    end else begin
      case (div_state)
        DIV_BUSY: begin
          if (div_step == '0) begin
            div_state <= DIV_DONE;
          end else begin
            div_step <= div_step - 1'b1;
          end
        end
        DIV_DONE: begin
          if (!out_stall) begin
            div_state <= DIV_IDLE;
          end
        end
        default: div_state <= DIV_IDLE;
      endcase
    end
  end

  // Restoring division step.
  assign trial      = {div_rem, div_dq[SUM_W-1]};
  assign trial_ok   = (trial >= {1'b0, hold_count});
  assign trial_diff = trial - {1'b0, hold_count};

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem    <= '0;
      div_dq     <= sum_next;
      hold_sum   <= sum_next;
      hold_count <= count_next;
      hold_ovf   <= ovf_next;
    end else if (div_state == DIV_BUSY) begin
      div_rem <= trial_ok ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      div_dq  <= {div_dq[SUM_W-2:0], trial_ok};
    end
  end

  // Result word.
  assign out_valid      = (div_state == DIV_DONE);
  assign mean_sq_error  = (hold_count == '0) ? '0 : div_dq[MEAN_W-1:0];
  assign sum_sq_error   = hold_sum;
  assign item_count     = hold_count;
  assign count_overflow = hold_ovf;

  // The count never passes its bound.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    acc_count[COUNT_BITS] |-> (acc_count[COUNT_BITS-1:0] == '0))
    else $error("position count passed its bound");

  // A new total is never handed over while a division is running.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    div_load |-> (div_state != DIV_BUSY))
    else $error("divider loaded while busy");

  // A result word appears only at the end of a division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(div_state == DIV_BUSY))
    else $error("result shown without a division");

  // A held last word stays in place with its value.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    freeze |=> (s5_valid && $stable(s5_sq) && $stable(s5_last)))
    else $error("stalled word lost or changed");

endmodule
